/* design/hpid_pkg.sv */
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared widths, constants, types and a wrap helper for the heading PID block.
// ----------------------------------------------------------------------------
package hpid_pkg;

    localparam int HeadW  = 16;
    localparam int GainW  = 16;
    localparam int DriveW = 6;
    localparam int SumW   = 32;
    localparam int WideW  = HeadW + 1;
    localparam int DiffW  = HeadW + 1;
    localparam int ProdPW = GainW + HeadW;
    localparam int ProdIW = GainW + SumW;
    localparam int ProdDW = GainW + DiffW;
    localparam int AccW   = ProdIW;

    localparam int HalfTurn   = 18000;
    localparam int FullTurn   = 36000;
    localparam int Deadband   = 100;
    localparam int DriveStep  = 25600;
    localparam int DriveLimit = 30;
    localparam int CntW       = $clog2(DriveLimit + 1);

    localparam logic signed [WideW-1:0] WrapHi   = WideW'(HalfTurn);
    localparam logic signed [WideW-1:0] WrapLo   = WideW'(-HalfTurn);
    localparam logic signed [WideW-1:0] WrapFull = WideW'(FullTurn);
    localparam logic signed [HeadW-1:0] DbHi     = HeadW'(Deadband);
    localparam logic signed [HeadW-1:0] DbLo     = HeadW'(-Deadband);

    typedef enum logic [1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic vld;
        logic dead;
    } t_stage_ctl;

    function automatic logic signed [WideW-1:0] wrap_once(input logic signed [WideW-1:0] c);
        logic signed [WideW-1:0] r;
        r = c;
        if (c < WrapLo) begin
            r = c + WrapFull;
        end else if (c > WrapHi) begin
            r = c - WrapFull;
        end
        return r;
    endfunction

endpackage

/* design/heading_pid_with_wrap_top.sv */
// ----------------------------------------------------------------------------
// heading_pid_with_wrap_top
// Heading PID controller with angle wrap, deadband and clamped drive output.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_target_heading, i_measured_heading
//  out       output     o_out_valid / i_out_ready   o_drive, o_on_target
//  cfg       input      i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  One request per cycle while the output is not stalled; a result passes
//  through the input reg, error/state stage, product stage, sum stage, result reg.
//  Controller state is updated in the error stage as each request passes, so back to
//  back requests see each other's state. Synchronous active-low reset clears
//  gains, state and valids. Stalls back up stage by stage; empty stages keep
//  taking requests while a result waits.
// ----------------------------------------------------------------------------
module heading_pid_with_wrap_top import hpid_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [HeadW-1:0]  i_target_heading,
    input  logic signed [HeadW-1:0]  i_measured_heading,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DriveW-1:0] o_drive,
    output logic                     o_on_target,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [GainW-1:0]         i_cfg_data
);

    logic                     r_vld_in;
    logic signed [HeadW-1:0]  r_target;
    logic signed [HeadW-1:0]  r_measured;
    logic signed [GainW-1:0]  r_gain_p;
    logic signed [GainW-1:0]  r_gain_i;
    logic signed [GainW-1:0]  r_gain_d;

    t_stage_ctl               ctl_err;
    t_stage_ctl               ctl_mul;
    logic signed [HeadW-1:0]  err;
    logic signed [DiffW-1:0]  diff;
    logic signed [SumW-1:0]   sum;
    logic signed [ProdPW-1:0] prod_p;
    logic signed [ProdIW-1:0] prod_i;
    logic signed [ProdDW-1:0] prod_d;
    logic                     rdy_drv;
    logic                     rdy_mul;
    logic                     rdy_err;

    assign rdy_mul    = !ctl_mul.vld || rdy_drv;
    assign rdy_err    = !ctl_err.vld || rdy_mul;
    assign o_in_ready = !r_vld_in || rdy_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_GAIN_P: r_gain_p <= i_cfg_data;
                REG_GAIN_I: r_gain_i <= i_cfg_data;
                REG_GAIN_D: r_gain_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
        end else if (o_in_ready) begin
            r_vld_in <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_target   <= i_target_heading;
            r_measured <= i_measured_heading;
        end
    end

    hpid_error u_error (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (rdy_err),
        .i_vld              (r_vld_in),
        .i_target_heading   (r_target),
        .i_measured_heading (r_measured),
        .o_ctl              (ctl_err),
        .o_error            (err),
        .o_diff             (diff),
        .o_sum              (sum)
    );

    hpid_mult u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (rdy_mul),
        .i_ctl    (ctl_err),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .i_error  (err),
        .i_diff   (diff),
        .i_sum    (sum),
        .o_ctl    (ctl_mul),
        .o_prod_p (prod_p),
        .o_prod_i (prod_i),
        .o_prod_d (prod_d)
    );

    hpid_drive u_drive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl_mul),
        .i_prod_p    (prod_p),
        .i_prod_i    (prod_i),
        .i_prod_d    (prod_d),
        .i_out_ready (i_out_ready),
        .o_ready     (rdy_drv),
        .o_out_valid (o_out_valid),
        .o_drive     (o_drive),
        .o_on_target (o_on_target)
    );

`ifndef SYNTHESIS
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive <= DriveW'(DriveLimit)) && (o_drive >= DriveW'(-DriveLimit)))
        else $error("drive out of range");

    a_deadband_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_on_target) |-> (o_drive == '0))
        else $error("nonzero drive inside deadband");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input blocked without output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif

endmodule

/* design/hpid_error.sv */
// ----------------------------------------------------------------------------
// hpid_error
// Heading error with angle wrap, deadband test and controller state update.
// ----------------------------------------------------------------------------
module hpid_error import hpid_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic                     i_vld,
    input  logic signed [HeadW-1:0]  i_target_heading,
    input  logic signed [HeadW-1:0]  i_measured_heading,
    output t_stage_ctl               o_ctl,
    output logic signed [HeadW-1:0]  o_error,
    output logic signed [DiffW-1:0]  o_diff,
    output logic signed [SumW-1:0]   o_sum
);

    logic                    r_vld;
    logic                    r_dead;
    logic signed [HeadW-1:0] r_err;
    logic signed [DiffW-1:0] r_diff;
    logic signed [SumW-1:0]  r_sum;
    logic signed [SumW-1:0]  r_error_sum;
    logic signed [HeadW-1:0] r_error_last;

    logic signed [WideW-1:0] raw;
    logic signed [WideW-1:0] wrapped;
    logic signed [HeadW-1:0] err;
    logic                    dead;
    logic signed [DiffW-1:0] diff;
    logic signed [SumW:0]    sum_ext;
    logic signed [SumW-1:0]  n_error_sum;

    always_comb begin
        raw     = WideW'(i_target_heading) - WideW'(i_measured_heading);
        wrapped = wrap_once(wrap_once(raw));
        err     = HeadW'(wrapped);
        dead    = (err > DbLo) && (err < DbHi);
        diff    = DiffW'(err) - DiffW'(r_error_last);
        sum_ext = (SumW + 1)'(r_error_sum) + (SumW + 1)'(err);
        if (sum_ext[SumW] != sum_ext[SumW-1]) begin
            n_error_sum = sum_ext[SumW] ? {1'b1, {(SumW - 1){1'b0}}}
                                        : {1'b0, {(SumW - 1){1'b1}}};
        end else begin
            n_error_sum = sum_ext[SumW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= 1'b0;
            r_error_sum  <= '0;
            r_error_last <= '0;
        end else if (i_load) begin
            r_vld <= i_vld;
            if (i_vld && !dead) begin
                r_error_sum  <= n_error_sum;
                r_error_last <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_vld) begin
            r_dead <= dead;
            r_err  <= err;
            r_diff <= diff;
            r_sum  <= r_error_sum;
        end
    end

    assign o_ctl   = '{vld: r_vld, dead: r_dead};
    assign o_error = r_err;
    assign o_diff  = r_diff;
    assign o_sum   = r_sum;

endmodule

/* design/hpid_mult.sv */
// ----------------------------------------------------------------------------
// hpid_mult
// Three parallel gain products, registered.
// ----------------------------------------------------------------------------
module hpid_mult import hpid_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  t_stage_ctl                i_ctl,
    input  logic signed [GainW-1:0]   i_gain_p,
    input  logic signed [GainW-1:0]   i_gain_i,
    input  logic signed [GainW-1:0]   i_gain_d,
    input  logic signed [HeadW-1:0]   i_error,
    input  logic signed [DiffW-1:0]   i_diff,
    input  logic signed [SumW-1:0]    i_sum,
    output t_stage_ctl                o_ctl,
    output logic signed [ProdPW-1:0]  o_prod_p,
    output logic signed [ProdIW-1:0]  o_prod_i,
    output logic signed [ProdDW-1:0]  o_prod_d
);

    logic                     r_vld;
    logic                     r_dead;
    logic signed [ProdPW-1:0] r_prod_p;
    logic signed [ProdIW-1:0] r_prod_i;
    logic signed [ProdDW-1:0] r_prod_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_ctl.vld) begin
            r_dead   <= i_ctl.dead;
            r_prod_p <= ProdPW'(i_gain_p) * ProdPW'(i_error);
            r_prod_i <= ProdIW'(i_gain_i) * ProdIW'(i_sum);
            r_prod_d <= ProdDW'(i_gain_d) * ProdDW'(i_diff);
        end
    end

    assign o_ctl    = '{vld: r_vld, dead: r_dead};
    assign o_prod_p = r_prod_p;
    assign o_prod_i = r_prod_i;
    assign o_prod_d = r_prod_d;

endmodule

/* design/hpid_drive.sv */
// ----------------------------------------------------------------------------
// hpid_drive
// PID sum, scaling by 25600 toward zero with clamp, and the result register.
// ----------------------------------------------------------------------------
module hpid_drive import hpid_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_stage_ctl                i_ctl,
    input  logic signed [ProdPW-1:0]  i_prod_p,
    input  logic signed [ProdIW-1:0]  i_prod_i,
    input  logic signed [ProdDW-1:0]  i_prod_d,
    input  logic                      i_out_ready,
    output logic                      o_ready,
    output logic                      o_out_valid,
    output logic signed [DriveW-1:0]  o_drive,
    output logic                      o_on_target
);

    logic                     r_vld_acc;
    logic                     r_dead_acc;
    logic signed [AccW-1:0]   r_acc;
    logic                     r_vld_out;
    logic signed [DriveW-1:0] r_drive;
    logic                     r_on_target;

    logic                     rdy_out;
    logic                     rdy_acc;
    logic [DriveLimit-1:0]    above;
    logic [DriveLimit-1:0]    below;
    logic [CntW-1:0]          cnt_pos;
    logic [CntW-1:0]          cnt_neg;
    logic signed [DriveW-1:0] drive_calc;

    assign rdy_out = !r_vld_out || i_out_ready;
    assign rdy_acc = !r_vld_acc || rdy_out;

    // thermometer against multiples of the scale step, both signs
    always_comb begin
        for (int k = 1; k <= DriveLimit; k++) begin
            above[k-1] = r_acc >= AccW'(k * DriveStep);
            below[k-1] = r_acc <= AccW'(-k * DriveStep);
        end
        cnt_pos    = CntW'($countones(above));
        cnt_neg    = CntW'($countones(below));
        drive_calc = DriveW'(cnt_pos) - DriveW'(cnt_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_acc <= 1'b0;
            r_vld_out <= 1'b0;
        end else begin
            if (rdy_acc) begin
                r_vld_acc <= i_ctl.vld;
            end
            if (rdy_out) begin
                r_vld_out <= r_vld_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_acc && i_ctl.vld) begin
            r_dead_acc <= i_ctl.dead;
            r_acc      <= AccW'(i_prod_p) + AccW'(i_prod_i) + AccW'(i_prod_d);
        end
        if (rdy_out && r_vld_acc) begin
            r_drive     <= r_dead_acc ? '0 : drive_calc;
            r_on_target <= r_dead_acc;
        end
    end

    assign o_ready     = rdy_acc;
    assign o_out_valid = r_vld_out;
    assign o_drive     = r_drive;
    assign o_on_target = r_on_target;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heading PID block. Requests are queued by the
// stimulus process, fed through a valid/ready driver with random source and
// sink idling, and every result is compared against an in-bench model of the
// wrapped-error PID controller. Covers directed corner headings, out-of-range
// headings, deadband edges and several gain settings including both extremes.
// ----------------------------------------------------------------------------
module tb;
    import hpid_pkg::*;

    localparam int         CycleLimit = 2_000_000;
    localparam int         DrainWait  = 8;
    localparam int         PhaseReqs  = 270;
    localparam logic [1:0] RegUnused  = 2'd3;

    typedef struct packed {
        logic signed [HeadW-1:0] target;
        logic signed [HeadW-1:0] measured;
    } heading_req_t;

    typedef struct packed {
        logic signed [DriveW-1:0] drive;
        logic                     on_target;
    } drive_res_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [HeadW-1:0]  i_target_heading = '0;
    logic signed [HeadW-1:0]  i_measured_heading = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DriveW-1:0] o_drive;
    logic                     o_on_target;
    logic                     i_cfg_we = 1'b0;
    logic [1:0]               i_cfg_idx = '0;
    logic [GainW-1:0]         i_cfg_data = '0;

    heading_req_t heading_backlog[$];
    drive_res_t   drive_due[$];

    logic signed [GainW-1:0] kp_gain;
    logic signed [GainW-1:0] ki_gain;
    logic signed [GainW-1:0] kd_gain;
    int                      err_accum;
    int                      err_prev;

    int n_issued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_cycles   = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    heading_pid_with_wrap_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_target_heading   (i_target_heading),
        .i_measured_heading (i_measured_heading),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_drive            (o_drive),
        .o_on_target        (o_on_target),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Wrapped-error PID step; updates integral and last error outside the deadband.
    function automatic drive_res_t heading_to_drive(heading_req_t req);
        longint     err;
        longint     acc;
        longint     cmd;
        longint     total;
        drive_res_t res;
        err = longint'($signed(req.target)) - longint'($signed(req.measured));
        repeat (2) begin
            if (err < -HalfTurn) begin
                err = err + FullTurn;
            end else if (err > HalfTurn) begin
                err = err - FullTurn;
            end
        end
        if (err > -Deadband && err < Deadband) begin
            res.drive     = '0;
            res.on_target = 1'b1;
            return res;
        end
        acc = longint'(kp_gain) * err + longint'(ki_gain) * longint'(err_accum)
            + longint'(kd_gain) * (err - longint'(err_prev));
        cmd = acc / DriveStep;
        if (cmd > DriveLimit) begin
            cmd = DriveLimit;
        end else if (cmd < -DriveLimit) begin
            cmd = -DriveLimit;
        end
        total = longint'(err_accum) + err;
        if (total > 64'sd2147483647) begin
            total = 64'sd2147483647;
        end else if (total < -64'sd2147483648) begin
            total = -64'sd2147483648;
        end
        err_accum     = int'(total);
        err_prev      = int'(err);
        res.drive     = DriveW'(cmd);
        res.on_target = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        drive_res_t want;
        if (!i_rst_n) begin
            kp_gain   = '0;
            ki_gain   = '0;
            kd_gain   = '0;
            err_accum = 0;
            err_prev  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_P: kp_gain = i_cfg_data;
                    REG_GAIN_I: ki_gain = i_cfg_data;
                    REG_GAIN_D: kd_gain = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                drive_due.push_back(heading_to_drive('{i_target_heading, i_measured_heading}));
                n_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (drive_due.size() == 0) begin
                    $error("unexpected result: drive %0d on_target %0d", o_drive, o_on_target);
                    n_errors++;
                end else begin
                    want = drive_due.pop_front();
                    n_checked++;
                    if (want.drive !== o_drive) begin
                        $error("drive mismatch: expected %0d, got %0d", want.drive, o_drive);
                        n_errors++;
                    end
                    if (want.on_target !== o_on_target) begin
                        $error("on_target mismatch: expected %0d, got %0d",
                               want.on_target, o_on_target);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : feed
        heading_req_t nxt;
        i_out_ready <= ($urandom_range(99) >= snk_idle_pct);
        if (n_accepted == n_issued) begin
            if (heading_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = heading_backlog.pop_front();
                i_target_heading   <= nxt.target;
                i_measured_heading <= nxt.measured;
                i_in_valid         <= 1'b1;
                n_issued++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_heading(int t, int m);
        heading_req_t req;
        req.target   = HeadW'(t);
        req.measured = HeadW'(m);
        heading_backlog.push_back(req);
    endtask

    function automatic int rand_ranged(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic queue_random_heading();
        int m;
        int sgn;
        m   = rand_ranged(-HalfTurn, HalfTurn);
        sgn = ($urandom_range(1) == 0) ? 1 : -1;
        case ($urandom_range(5))
            0:       queue_heading(int'($urandom_range(65535)), int'($urandom_range(65535)));
            1, 2:    queue_heading(rand_ranged(-HalfTurn, HalfTurn), m);
            3:       queue_heading(m + rand_ranged(-150, 150), m);
            4:       queue_heading(m + sgn * rand_ranged(HalfTurn - 100, HalfTurn + 100), m);
            default: queue_heading(m + sgn * rand_ranged(Deadband - 1, Deadband), m);
        endcase
    endtask

    task automatic wait_idle();
        while (heading_backlog.size() != 0 || n_accepted != n_issued || drive_due.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= GainW'(val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_gains(int p, int i, int d);
        write_gain(REG_GAIN_P, p);
        write_gain(REG_GAIN_I, i);
        write_gain(REG_GAIN_D, d);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 12;
        snk_idle_pct = 76;
        set_gains(256, 4, 512);
        queue_heading(0, 0);
        queue_heading(99, 0);
        queue_heading(-99, 0);
        queue_heading(100, 0);
        queue_heading(-100, 0);
        queue_heading(HalfTurn, 0);
        queue_heading(-HalfTurn, 0);
        queue_heading(HalfTurn + 1, 0);
        queue_heading(-HalfTurn - 1, 0);
        queue_heading(HalfTurn, -HalfTurn);
        queue_heading(32767, -32768);
        queue_heading(-32768, 32767);
        queue_heading(32767, 32767);
        queue_heading(-32768, -32768);
        queue_heading(-32768, 0);
        queue_heading(32767, 0);
        queue_heading(0, -32768);
        queue_heading(0, 32767);
        queue_heading(17950, -17950);
        queue_heading(-17950, 17951);
        queue_heading(5000, 1000);
        queue_heading(-3000, 2000);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            src_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 76 : 0;
            snk_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 12 : 0;
            case (ph)
                0: set_gains(384, 2, 512);
                1: set_gains(32767, 32767, 32767);
                2: set_gains(-32768, -32768, -32768);
                3: set_gains(int'($urandom_range(65535)), int'($urandom_range(65535)),
                             int'($urandom_range(65535)));
                4: begin
                    set_gains(0, 0, 0);
                    write_gain(RegUnused, 16'h5a5a);
                end
                default: set_gains(rand_ranged(-1024, 1024), rand_ranged(-64, 64),
                                   rand_ranged(-1024, 1024));
            endcase
            for (int k = 0; k < PhaseReqs; k++)
                queue_random_heading();
            wait_idle();
        end

        $display("tb: %0d requests, %0d results checked, %0d mismatches",
                 n_accepted, n_checked, n_errors);
        $display("tb: corner headings, wrap and deadband edges, seven gain sets, three idle mixes");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
design/hpid_pkg.sv
design/hpid_error.sv
design/hpid_mult.sv
design/hpid_drive.sv
design/heading_pid_with_wrap_top.sv
test/tb.sv
